@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/drfl_pkg.sv @@
// ----------------------------------------------------------------------------
// drfl_pkg
// Types and constants for the detection row filter / landmark decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package drfl_pkg;

  localparam int NUM_CLASSES = 6;
  localparam int NUM_POINTS  = 5;
  localparam int POINT_SLOTS = 5;   // point slots carried in a row / result
  localparam int PTS_USED    = (NUM_POINTS < POINT_SLOTS) ? NUM_POINTS : POINT_SLOTS;

  localparam int SCORE_W   = 10;
  localparam int SCORES_W  = 60;
  localparam int COORD_W   = 16;
  localparam int CLASS_W   = 3;
  localparam int MASK_W    = 6;
  localparam int PAD_W     = 10;
  localparam int SCALE_W   = 24;

  // register map (word index)
  localparam logic [2:0] REG_BOX_THR   = 3'd0;
  localparam logic [2:0] REG_CLASS_THR = 3'd1;
  localparam logic [2:0] REG_CLASS_MSK = 3'd2;
  localparam logic [2:0] REG_PAD_X     = 3'd3;
  localparam logic [2:0] REG_PAD_Y     = 3'd4;
  localparam logic [2:0] REG_INV_SCALE = 3'd5;

  localparam logic [SCORE_W-1:0] BOX_THR_RST   = 10'd716;
  localparam logic [SCORE_W-1:0] CLASS_THR_RST = 10'd666;
  localparam logic [MASK_W-1:0]  CLASS_MSK_RST = 6'd18;
  localparam logic [PAD_W-1:0]   PAD_RST       = 10'd0;
  localparam logic [SCALE_W-1:0] INV_SCALE_RST = 24'd65536;

  typedef struct packed {
    logic [SCORE_W-1:0]         obj_score;
    logic [SCORES_W-1:0]        class_scores;
    logic signed [COORD_W-1:0]  p0_x;
    logic signed [COORD_W-1:0]  p0_y;
    logic signed [COORD_W-1:0]  p1_x;
    logic signed [COORD_W-1:0]  p1_y;
    logic signed [COORD_W-1:0]  p2_x;
    logic signed [COORD_W-1:0]  p2_y;
    logic signed [COORD_W-1:0]  p3_x;
    logic signed [COORD_W-1:0]  p3_y;
    logic signed [COORD_W-1:0]  p4_x;
    logic signed [COORD_W-1:0]  p4_y;
  } in_item_t;

  typedef struct packed {
    logic [CLASS_W-1:0]         class_id;
    logic [SCORE_W-1:0]         class_score;
    logic signed [COORD_W-1:0]  box_left;
    logic signed [COORD_W-1:0]  box_top;
    logic [COORD_W-1:0]         box_width;
    logic [COORD_W-1:0]         box_height;
    logic [63:0]                points_01;
    logic [63:0]                points_23;
    logic [31:0]                point_4;
  } out_item_t;

endpackage

`default_nettype wire

@@ rtl/detection_row_filter_landmark_decode.sv @@
// ----------------------------------------------------------------------------
// detection_row_filter_landmark_decode
// Filters detector rows on objectness, best class and class mask, and maps
// the landmark points of a kept row back to image space with their bounds.
// ----------------------------------------------------------------------------
//
//   channel  handshake                    payload
//   -------  ---------------------------  -----------------------
//   input    start / busy                 in_item  (in_item_t)
//   result   out_valid (one-cycle strobe) out_item (out_item_t)
//   config   psel/penable/pwrite/pready   paddr, pwdata, prdata
//
// One request per cycle; busy is never raised. For a kept row, out_valid rises
// after its request passes the input register, point mapping (one multiplier
// per coordinate) into the stage B register and the bounding rectangle into
// the result register. Dropped rows produce nothing. rst_n clears the pipeline
// valids and loads the register reset values. The receiver cannot stall.
`default_nettype none

`include "assert_macros.svh"

module detection_row_filter_landmark_decode #(
  parameter int NUM_CLASSES = drfl_pkg::NUM_CLASSES,
  parameter int NUM_POINTS  = drfl_pkg::NUM_POINTS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input channel
  input  wire logic                 start,
  output logic                      busy,
  input  wire drfl_pkg::in_item_t   in_item,
  // result channel
  output logic                      out_valid,
  output drfl_pkg::out_item_t       out_item,
  // configuration
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [4:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int SW  = drfl_pkg::SCORE_W;
  localparam int CW  = drfl_pkg::COORD_W;
  localparam int NPS = drfl_pkg::POINT_SLOTS;
  localparam int PTS_USED = (NUM_POINTS < NPS) ? NUM_POINTS : NPS;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [SW-1:0]                 box_thr_r;
  logic [SW-1:0]                 class_thr_r;
  logic [drfl_pkg::MASK_W-1:0]   class_msk_r;
  logic [drfl_pkg::PAD_W-1:0]    pad_x_r;
  logic [drfl_pkg::PAD_W-1:0]    pad_y_r;
  logic [drfl_pkg::SCALE_W-1:0]  inv_scale_r;
  logic                          cfg_wr;
  logic [2:0]                    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_thr_r   <= drfl_pkg::BOX_THR_RST;
      class_thr_r <= drfl_pkg::CLASS_THR_RST;
      class_msk_r <= drfl_pkg::CLASS_MSK_RST;
      pad_x_r     <= drfl_pkg::PAD_RST;
      pad_y_r     <= drfl_pkg::PAD_RST;
      inv_scale_r <= drfl_pkg::INV_SCALE_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        drfl_pkg::REG_BOX_THR:   box_thr_r   <= pwdata[SW-1:0];
        drfl_pkg::REG_CLASS_THR: class_thr_r <= pwdata[SW-1:0];
        drfl_pkg::REG_CLASS_MSK: class_msk_r <= pwdata[drfl_pkg::MASK_W-1:0];
        drfl_pkg::REG_PAD_X:     pad_x_r     <= pwdata[drfl_pkg::PAD_W-1:0];
        drfl_pkg::REG_PAD_Y:     pad_y_r     <= pwdata[drfl_pkg::PAD_W-1:0];
        drfl_pkg::REG_INV_SCALE: inv_scale_r <= pwdata[drfl_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      drfl_pkg::REG_BOX_THR:   prdata = {22'd0, box_thr_r};
      drfl_pkg::REG_CLASS_THR: prdata = {22'd0, class_thr_r};
      drfl_pkg::REG_CLASS_MSK: prdata = {26'd0, class_msk_r};
      drfl_pkg::REG_PAD_X:     prdata = {22'd0, pad_x_r};
      drfl_pkg::REG_PAD_Y:     prdata = {22'd0, pad_y_r};
      drfl_pkg::REG_INV_SCALE: prdata = {8'd0, inv_scale_r};
      default:                 prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Point mapping: ((p - pad*16) / 16) * inv_scale / 65536, both divisions
  // truncating toward zero, then saturate to 16 bits.
  // --------------------------------------------------------------------------
  function automatic logic signed [CW-1:0] map_coord(
    input logic signed [CW-1:0]          p,
    input logic [drfl_pkg::PAD_W-1:0]    pad,
    input logic [drfl_pkg::SCALE_W-1:0]  inv
  );
    logic signed [16:0] d;
    logic signed [16:0] d_bias;
    logic signed [12:0] t;
    logic signed [37:0] prod;
    logic signed [37:0] p_bias;
    logic signed [21:0] m;
    logic signed [CW-1:0] res;
    d      = $signed({p[CW-1], p}) - $signed({3'b000, pad, 4'b0000});
    d_bias = d + (d[16] ? 17'sd15 : 17'sd0);
    t      = d_bias[16:4];
    prod   = t * $signed({1'b0, inv});
    p_bias = prod + (prod[37] ? 38'sd65535 : 38'sd0);
    m      = p_bias[37:16];
    if (m > 22'sd32767) begin
      res = 16'sh7fff;
    end else if (m < -22'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = m[CW-1:0];
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stage A: input register
  // --------------------------------------------------------------------------
  logic                 valid_a_r;
  drfl_pkg::in_item_t   item_a_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
    end else begin
      valid_a_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      item_a_r <= in_item;
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: filter and map
  // --------------------------------------------------------------------------
  logic [SW-1:0]                   score_a [NUM_CLASSES];
  logic [SW-1:0]                   best_score;
  logic [drfl_pkg::CLASS_W-1:0]    best_id;
  logic                            keep_a;
  logic signed [CW-1:0]            pin_x [NPS];
  logic signed [CW-1:0]            pin_y [NPS];

  always_comb begin
    for (int i = 0; i < NUM_CLASSES; i++) begin
      if ((i + 1) * SW <= drfl_pkg::SCORES_W) begin
        score_a[i] = item_a_r.class_scores[i*SW +: SW];
      end else begin
        score_a[i] = '0;
      end
    end
  end

  // first index holding the maximum
  always_comb begin
    best_score = score_a[0];
    best_id    = '0;
    for (int i = 1; i < NUM_CLASSES; i++) begin
      if (score_a[i] > best_score) begin
        best_score = score_a[i];
        best_id    = drfl_pkg::CLASS_W'(i);
      end
    end
  end

  always_comb begin
    keep_a = valid_a_r
          && (item_a_r.obj_score > box_thr_r)
          && (best_score >= class_thr_r)
          && (best_id < drfl_pkg::CLASS_W'(drfl_pkg::MASK_W))
          && class_msk_r[best_id];
  end

  always_comb begin
    pin_x[0] = item_a_r.p0_x;  pin_y[0] = item_a_r.p0_y;
    pin_x[1] = item_a_r.p1_x;  pin_y[1] = item_a_r.p1_y;
    pin_x[2] = item_a_r.p2_x;  pin_y[2] = item_a_r.p2_y;
    pin_x[3] = item_a_r.p3_x;  pin_y[3] = item_a_r.p3_y;
    pin_x[4] = item_a_r.p4_x;  pin_y[4] = item_a_r.p4_y;
  end

  logic                            valid_b_r;
  logic [drfl_pkg::CLASS_W-1:0]    class_id_b_r;
  logic [SW-1:0]                   class_score_b_r;
  logic signed [CW-1:0]            px_b_r [NPS];
  logic signed [CW-1:0]            py_b_r [NPS];
  logic signed [CW-1:0]            px_nxt [NPS];
  logic signed [CW-1:0]            py_nxt [NPS];

  // slots past the used point count stay zero
  always_comb begin
    for (int i = 0; i < NPS; i++) begin
      if (i < PTS_USED) begin
        px_nxt[i] = map_coord(pin_x[i], pad_x_r, inv_scale_r);
        py_nxt[i] = map_coord(pin_y[i], pad_y_r, inv_scale_r);
      end else begin
        px_nxt[i] = '0;
        py_nxt[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_b_r <= 1'b0;
    end else begin
      valid_b_r <= keep_a;
    end
  end

  always_ff @(posedge clk) begin
    if (keep_a) begin
      class_id_b_r    <= best_id;
      class_score_b_r <= best_score;
      px_b_r          <= px_nxt;
      py_b_r          <= py_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: bounding rectangle, result register
  // --------------------------------------------------------------------------
  logic signed [CW-1:0]  xmin, xmax, ymin, ymax;
  logic [CW:0]           wspan, hspan;
  drfl_pkg::out_item_t   item_nxt;
  logic                  out_valid_r;
  drfl_pkg::out_item_t   out_item_r;

  always_comb begin
    xmin = px_b_r[0];  xmax = px_b_r[0];
    ymin = py_b_r[0];  ymax = py_b_r[0];
    for (int i = 1; i < PTS_USED; i++) begin
      if (px_b_r[i] < xmin) xmin = px_b_r[i];
      if (px_b_r[i] > xmax) xmax = px_b_r[i];
      if (py_b_r[i] < ymin) ymin = py_b_r[i];
      if (py_b_r[i] > ymax) ymax = py_b_r[i];
    end
  end

  // max >= min, so the 17-bit difference plus one is in 1..65536
  assign wspan = ({xmax[CW-1], xmax} - {xmin[CW-1], xmin}) + 17'd1;
  assign hspan = ({ymax[CW-1], ymax} - {ymin[CW-1], ymin}) + 17'd1;

  always_comb begin
    item_nxt.class_id    = class_id_b_r;
    item_nxt.class_score = class_score_b_r;
    item_nxt.box_left    = xmin;
    item_nxt.box_top     = ymin;
    item_nxt.box_width   = wspan[CW] ? 16'hffff : wspan[CW-1:0];
    item_nxt.box_height  = hspan[CW] ? 16'hffff : hspan[CW-1:0];
    item_nxt.points_01   = {py_b_r[1], px_b_r[1], py_b_r[0], px_b_r[0]};
    item_nxt.points_23   = {py_b_r[3], px_b_r[3], py_b_r[2], px_b_r[2]};
    item_nxt.point_4     = {py_b_r[4], px_b_r[4]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= valid_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_b_r) begin
      out_item_r <= item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `ASSERT_NEXT(a_kept_row_reaches_out, clk, rst_n, valid_b_r, out_valid_r)
  `ASSERT_IMPL(a_out_from_request, clk, rst_n, out_valid_r, $past(valid_a_r, 2))
  `ASSERT_IMPL(a_rect_nonzero, clk, rst_n, out_valid_r,
               (out_item_r.box_width != 16'd0) && (out_item_r.box_height != 16'd0))
  `ASSERT_IMPL(a_left_bounds_p0, clk, rst_n, out_valid_r,
               $signed(out_item_r.points_01[15:0]) >= out_item_r.box_left)
  `ASSERT_IMPL(a_class_in_range, clk, rst_n, out_valid_r,
               out_item_r.class_id < drfl_pkg::CLASS_W'(drfl_pkg::MASK_W))

endmodule

`default_nettype wire

@@ test/detection_row_filter_landmark_decode_tb.sv @@
// ----------------------------------------------------------------------------
// detection_row_filter_landmark_decode_tb
// Drives detector rows through the row filter / landmark decoder, predicts
// the kept rows and their mapped points, and checks every result strobe.
// Register settings change between phases over the APB-style port.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module detection_row_filter_landmark_decode_tb;

  localparam int SCORE_W     = drfl_pkg::SCORE_W;
  localparam int SCORES_W    = drfl_pkg::SCORES_W;
  localparam int COORD_W     = drfl_pkg::COORD_W;
  localparam int CLASS_W     = drfl_pkg::CLASS_W;
  localparam int MASK_W      = drfl_pkg::MASK_W;
  localparam int PAD_W       = drfl_pkg::PAD_W;
  localparam int SCALE_W     = drfl_pkg::SCALE_W;
  localparam int NUM_CLASSES = drfl_pkg::NUM_CLASSES;
  localparam int POINT_SLOTS = drfl_pkg::POINT_SLOTS;
  localparam int PTS_USED    = drfl_pkg::PTS_USED;

  localparam int CLK_HALF        = 5;
  localparam int RESET_CYCLES    = 6;
  localparam int PIPE_LAT        = 3;
  localparam int N_PHASES        = 7;
  localparam int ITEMS_PER_PHASE = 165;
  localparam logic [2:0] REG_UNMAPPED = drfl_pkg::REG_INV_SCALE + 3'd1;
  localparam logic [159:0] PTS_ZERO = '0;

  typedef enum logic [1:0] {ROW_CHECK, ROW_KEEP, ROW_DROP, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    drfl_pkg::in_item_t   item;
    drfl_pkg::out_item_t  want;
    logic [2:0]           reg_idx;
    logic [31:0]          reg_val;
  } bench_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  drfl_pkg::in_item_t   in_item = '0;
  logic                 out_valid;
  drfl_pkg::out_item_t  out_item;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [4:0]           paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  // register copies used by the decoder model
  logic [SCORE_W-1:0] box_thr   = drfl_pkg::BOX_THR_RST;
  logic [SCORE_W-1:0] cls_thr   = drfl_pkg::CLASS_THR_RST;
  logic [MASK_W-1:0]  cls_mask  = drfl_pkg::CLASS_MSK_RST;
  logic [PAD_W-1:0]   pad_x     = drfl_pkg::PAD_RST;
  logic [PAD_W-1:0]   pad_y     = drfl_pkg::PAD_RST;
  logic [SCALE_W-1:0] inv_scale = drfl_pkg::INV_SCALE_RST;

  drfl_pkg::out_item_t  landmark_q[$];
  bench_row_t           bench_rows[$];
  int                   mismatches = 0;

  detection_row_filter_landmark_decode dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #CLK_HALF clk = ~clk;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("%0t: %s got %h expected %h", $time, what, got, want);
  endtask

  task automatic add_row(input bench_row_t br);
    bench_rows.insert(bench_rows.size(), br);
  endtask

  task automatic expect_row(input drfl_pkg::out_item_t o);
    landmark_q.insert(landmark_q.size(), o);
  endtask

  // network pixel (Q12.4) -> image pixel, truncating toward zero twice
  function automatic int map_point(input logic signed [COORD_W-1:0] p,
                                   input logic [PAD_W-1:0] pad);
    int     d, t;
    longint m;
    d = int'(p) - int'(pad) * 16;
    t = d / 16;
    m = (longint'(t) * longint'(inv_scale)) / 65536;
    if (m > 32767) m = 32767;
    if (m < -32768) m = -32768;
    return int'(m);
  endfunction

  function automatic logic [COORD_W-1:0] span_of(input int lo, input int hi);
    int w;
    w = hi - lo + 1;
    return (w > 65535) ? 16'hFFFF : 16'(w);
  endfunction

  // returns 1 when the row is kept, with the decoded landmarks in o
  function automatic bit decode_row(input drfl_pkg::in_item_t r,
                                    output drfl_pkg::out_item_t o);
    logic [SCORE_W-1:0] s, best_s;
    int best;
    int xs[POINT_SLOTS], ys[POINT_SLOTS];
    logic signed [COORD_W-1:0] raw[2*POINT_SLOTS];
    int xmin, xmax, ymin, ymax;
    o = '0;
    raw = '{r.p0_x, r.p0_y, r.p1_x, r.p1_y, r.p2_x, r.p2_y,
            r.p3_x, r.p3_y, r.p4_x, r.p4_y};
    if (r.obj_score <= box_thr) return 1'b0;
    best = 0;
    best_s = r.class_scores[SCORE_W-1:0];
    for (int i = 1; i < NUM_CLASSES; i++) begin
      s = (i < SCORES_W / SCORE_W) ? r.class_scores[i*SCORE_W +: SCORE_W] : '0;
      if (s > best_s) begin
        best_s = s;
        best = i;
      end
    end
    if (best_s < cls_thr) return 1'b0;
    if (best >= MASK_W || !cls_mask[best]) return 1'b0;
    for (int i = 0; i < POINT_SLOTS; i++) begin
      xs[i] = 0;
      ys[i] = 0;
    end
    for (int i = 0; i < PTS_USED; i++) begin
      xs[i] = map_point(raw[2*i], pad_x);
      ys[i] = map_point(raw[2*i+1], pad_y);
    end
    xmin = xs[0]; xmax = xs[0];
    ymin = ys[0]; ymax = ys[0];
    for (int i = 1; i < PTS_USED; i++) begin
      if (xs[i] < xmin) xmin = xs[i];
      if (xs[i] > xmax) xmax = xs[i];
      if (ys[i] < ymin) ymin = ys[i];
      if (ys[i] > ymax) ymax = ys[i];
    end
    o.class_id    = CLASS_W'(best);
    o.class_score = best_s;
    o.box_left    = 16'(xmin);
    o.box_top     = 16'(ymin);
    o.box_width   = span_of(xmin, xmax);
    o.box_height  = span_of(ymin, ymax);
    o.points_01   = {16'(ys[1]), 16'(xs[1]), 16'(ys[0]), 16'(xs[0])};
    o.points_23   = {16'(ys[3]), 16'(xs[3]), 16'(ys[2]), 16'(xs[2])};
    o.point_4     = {16'(ys[4]), 16'(xs[4])};
    return 1'b1;
  endfunction

  function automatic logic [SCORES_W-1:0] one_class(input int idx,
                                                    input logic [SCORE_W-1:0] s);
    return SCORES_W'(s) << (idx * SCORE_W);
  endfunction

  function automatic drfl_pkg::in_item_t mk_row(input logic [SCORE_W-1:0] b,
                                                input logic [SCORES_W-1:0] sc,
                                                input logic [159:0] pts);
    return {b, sc, pts};
  endfunction

  // mostly rows that pass the filter under the current settings, rest noise
  function automatic drfl_pkg::in_item_t gen_row();
    drfl_pkg::in_item_t r;
    logic [255:0] bits;
    int cls, top, p;
    logic [SCORE_W-1:0] sc;
    bits = {$urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom};
    r = bits[$bits(drfl_pkg::in_item_t)-1:0];
    if ($urandom_range(0, 99) < 75) begin
      r.obj_score = (box_thr == '1) ? '1 : SCORE_W'($urandom_range(box_thr + 1, 1023));
      if (cls_mask == '0)
        cls = $urandom_range(0, NUM_CLASSES - 1);
      else begin
        do cls = $urandom_range(0, NUM_CLASSES - 1);
        while (cls >= MASK_W || !cls_mask[cls]);
      end
      top = $urandom_range(cls_thr, 1023);
      for (int i = 0; i < NUM_CLASSES && i < SCORES_W / SCORE_W; i++) begin
        if (i == cls || $urandom_range(0, 7) == 0) sc = SCORE_W'(top);
        else sc = SCORE_W'($urandom_range(0, top));
        r.class_scores[i*SCORE_W +: SCORE_W] = sc;
      end
    end
    // points close to the pad edge, where the truncation matters
    if ($urandom_range(0, 1) == 0) begin
      for (int k = 0; k < 2 * POINT_SLOTS; k++) begin
        p = int'((k % 2 == 0) ? pad_x : pad_y) * 16
            + int'($urandom_range(0, 4095)) - 2048;
        r[159 - 16*k -: 16] = 16'(p);
      end
    end
    return r;
  endfunction

  task automatic apb_xfer(input bit wr, input logic [2:0] idx,
                          input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_reg(input logic [2:0] idx, input logic [31:0] val);
    logic [31:0] want, got;
    want = '0;
    apb_xfer(1'b1, idx, val, got);
    case (idx)
      drfl_pkg::REG_BOX_THR: begin
        box_thr = val[SCORE_W-1:0];
        want = 32'(box_thr);
      end
      drfl_pkg::REG_CLASS_THR: begin
        cls_thr = val[SCORE_W-1:0];
        want = 32'(cls_thr);
      end
      drfl_pkg::REG_CLASS_MSK: begin
        cls_mask = val[MASK_W-1:0];
        want = 32'(cls_mask);
      end
      drfl_pkg::REG_PAD_X: begin
        pad_x = val[PAD_W-1:0];
        want = 32'(pad_x);
      end
      drfl_pkg::REG_PAD_Y: begin
        pad_y = val[PAD_W-1:0];
        want = 32'(pad_y);
      end
      drfl_pkg::REG_INV_SCALE: begin
        inv_scale = val[SCALE_W-1:0];
        want = 32'(inv_scale);
      end
      default: ;  // unmapped: write is dropped
    endcase
    if (idx <= drfl_pkg::REG_INV_SCALE) begin
      apb_xfer(1'b0, idx, '0, got);
      if (got !== want) report_mismatch("register readback", 64'(got), 64'(want));
    end
  endtask

  // request held until accepted; start stays high for a following request
  task automatic send_row(input drfl_pkg::in_item_t r);
    start   <= 1'b1;
    in_item <= r;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_maybe(input bit allow);
    if (allow && $urandom_range(0, 99) < 7) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // dropped rows leave no trace, so give the pipeline time to empty
  task automatic quiesce();
    start <= 1'b0;
    while (landmark_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  always @(posedge clk) begin
    drfl_pkg::out_item_t want;
    if (rst_n && out_valid) begin
      if (landmark_q.size() == 0)
        report_mismatch("result with nothing pending", 64'(out_item.class_id), '0);
      else begin
        want = landmark_q.pop_front();
        if (out_item.class_id !== want.class_id)
          report_mismatch("class_id", 64'(out_item.class_id), 64'(want.class_id));
        if (out_item.class_score !== want.class_score)
          report_mismatch("class_score", 64'(out_item.class_score), 64'(want.class_score));
        if (out_item.box_left !== want.box_left)
          report_mismatch("box_left", 64'(out_item.box_left), 64'(want.box_left));
        if (out_item.box_top !== want.box_top)
          report_mismatch("box_top", 64'(out_item.box_top), 64'(want.box_top));
        if (out_item.box_width !== want.box_width)
          report_mismatch("box_width", 64'(out_item.box_width), 64'(want.box_width));
        if (out_item.box_height !== want.box_height)
          report_mismatch("box_height", 64'(out_item.box_height), 64'(want.box_height));
        if (out_item.points_01 !== want.points_01)
          report_mismatch("points_01", out_item.points_01, want.points_01);
        if (out_item.points_23 !== want.points_23)
          report_mismatch("points_23", out_item.points_23, want.points_23);
        if (out_item.point_4 !== want.point_4)
          report_mismatch("point_4", 64'(out_item.point_4), 64'(want.point_4));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("detection_row_filter_landmark_decode: mismatch");
    $finish;
  end

  initial begin
    drfl_pkg::in_item_t   r;
    drfl_pkg::out_item_t  o;
    logic [31:0]          cfg_v[6];

    // reset settings: classes 1 and 4 allowed, unit scale, no pad
    add_row('{ROW_DROP, mk_row(10'd716, one_class(1, 10'd1023), PTS_ZERO),
              '0, '0, '0});
    add_row('{ROW_KEEP, mk_row(10'd717, one_class(1, 10'd666), PTS_ZERO),
        drfl_pkg::out_item_t'({3'd1, 10'd666, 16'd0, 16'd0, 16'd1, 16'd1,
                               64'd0, 64'd0, 32'd0}),
        '0, '0});
    add_row('{ROW_DROP, mk_row(10'd1023, one_class(1, 10'd665), PTS_ZERO),
              '0, '0, '0});
    add_row('{ROW_DROP, mk_row(10'd1023, one_class(0, 10'd1023), PTS_ZERO),
              '0, '0, '0});
    add_row('{ROW_KEEP, mk_row(10'd1023, one_class(4, 10'd1023),
                               {16'd16, 16'd32, 128'd0}),
        drfl_pkg::out_item_t'({3'd4, 10'd1023, 16'd0, 16'd0, 16'd2, 16'd3,
                               64'h0000_0000_0002_0001, 64'd0, 32'd0}),
        '0, '0});
    // ties go to the lower class index
    add_row('{ROW_DROP, mk_row(10'd1023,
        one_class(0, 10'd800) | one_class(1, 10'd800), PTS_ZERO), '0, '0, '0});
    add_row('{ROW_KEEP, mk_row(10'd1023,
        one_class(1, 10'd900) | one_class(4, 10'd900), PTS_ZERO),
        drfl_pkg::out_item_t'({3'd1, 10'd900, 16'd0, 16'd0, 16'd1, 16'd1,
                               64'd0, 64'd0, 32'd0}),
        '0, '0});
    add_row('{ROW_DROP, mk_row(10'd0, '0, PTS_ZERO), '0, '0, '0});
    add_row('{ROW_CHECK, mk_row(10'd1023, one_class(1, 10'd700),
        {16'hFFFF, 16'hFFEF, 16'hFFF1, 16'hFFF0, 16'd15,
         16'd31, 16'd47, 16'hFFD0, 16'd0, 16'd1}), '0, '0, '0});
    add_row('{ROW_CHECK, mk_row(10'd1023, one_class(4, 10'd1023),
        {16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000,
         16'h8000, 16'h7FFF, 16'h7FFF, 16'h0000, 16'hFFFF}), '0, '0, '0});
    add_row('{ROW_DROP, mk_row(10'd1023, '1, PTS_ZERO), '0, '0, '0});
    add_row('{ROW_DROP, mk_row(10'd1023, one_class(5, 10'd1023), PTS_ZERO),
              '0, '0, '0});
    // zero inverse scale collapses every point
    add_row('{ROW_CFG, '0, '0, drfl_pkg::REG_INV_SCALE, 32'd0});
    add_row('{ROW_KEEP, mk_row(10'd1023, one_class(1, 10'd1023),
        {16'h1234, 16'hEDCB, 16'h7FFF, 16'h8000, 16'h0FF0,
         16'hF00F, 16'h5555, 16'hAAAA, 16'h0001, 16'hFFFF}),
        drfl_pkg::out_item_t'({3'd1, 10'd1023, 16'd0, 16'd0, 16'd1, 16'd1,
                               64'd0, 64'd0, 32'd0}),
        '0, '0});
    // saturated corners, rectangle span clips at 65535
    add_row('{ROW_CFG, '0, '0, drfl_pkg::REG_INV_SCALE, 32'hFF_FFFF});
    add_row('{ROW_KEEP, mk_row(10'd1023, one_class(1, 10'd1023),
        {16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 96'd0}),
        drfl_pkg::out_item_t'({3'd1, 10'd1023, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF,
                               64'h7FFF_7FFF_8000_8000, 64'd0, 32'd0}),
        '0, '0});
    add_row('{ROW_CFG, '0, '0, drfl_pkg::REG_PAD_X, 32'd1023});
    add_row('{ROW_CFG, '0, '0, drfl_pkg::REG_PAD_Y, 32'd1023});
    add_row('{ROW_CFG, '0, '0, drfl_pkg::REG_INV_SCALE, 32'd98304});
    add_row('{ROW_CHECK, mk_row(10'd1023, one_class(4, 10'd1023),
        {16'd16368, 16'd16367, 16'd0, 16'h7FFF, 16'h8000,
         16'd16384, 16'd16383, 16'd20000, 16'd100, 16'hFFFB}), '0, '0, '0});
    add_row('{ROW_CHECK, mk_row(10'd1023, one_class(1, 10'd1023),
        {16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000,
         16'h8000, 16'h7FFF, 16'h7FFF, 16'h0000, 16'hFFFF}), '0, '0, '0});
    add_row('{ROW_CFG, '0, '0, drfl_pkg::REG_BOX_THR, 32'd0});
    add_row('{ROW_CFG, '0, '0, drfl_pkg::REG_CLASS_THR, 32'd0});
    add_row('{ROW_CFG, '0, '0, drfl_pkg::REG_CLASS_MSK, 32'd63});
    add_row('{ROW_CHECK, mk_row(10'd1, '0, PTS_ZERO), '0, '0, '0});
    add_row('{ROW_DROP, mk_row(10'd0, '1, PTS_ZERO), '0, '0, '0});
    add_row('{ROW_CFG, '0, '0, drfl_pkg::REG_BOX_THR, 32'd1023});
    add_row('{ROW_DROP, mk_row(10'd1023, '1, PTS_ZERO), '0, '0, '0});
    // writes past the register map must not disturb the threshold
    add_row('{ROW_CFG, '0, '0, REG_UNMAPPED, 32'd0});
    add_row('{ROW_CFG, '0, '0, REG_UNMAPPED + 3'd1, 32'hFFFF_FFFF});
    add_row('{ROW_DROP, mk_row(10'd1023, '1, PTS_ZERO), '0, '0, '0});

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (bench_rows[k]) begin
      if (bench_rows[k].kind == ROW_CFG) begin
        quiesce();
        set_reg(bench_rows[k].reg_idx, bench_rows[k].reg_val);
      end else begin
        send_row(bench_rows[k].item);
        case (bench_rows[k].kind)
          ROW_KEEP:  expect_row(bench_rows[k].want);
          ROW_CHECK: if (decode_row(bench_rows[k].item, o)) expect_row(o);
          default: ;
        endcase
        idle_maybe(1'b1);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      quiesce();
      cfg_v[drfl_pkg::REG_BOX_THR]   = $urandom_range(0, 1000);
      cfg_v[drfl_pkg::REG_CLASS_THR] = $urandom_range(0, 1023);
      cfg_v[drfl_pkg::REG_CLASS_MSK] = $urandom_range(1, 63);
      cfg_v[drfl_pkg::REG_PAD_X]     = $urandom_range(0, 1023);
      cfg_v[drfl_pkg::REG_PAD_Y]     = $urandom_range(0, 1023);
      cfg_v[drfl_pkg::REG_INV_SCALE] = $urandom_range(0, 24'hFF_FFFF) >> $urandom_range(0, 8);
      case (ph)
        0: cfg_v = '{32'(drfl_pkg::BOX_THR_RST), 32'(drfl_pkg::CLASS_THR_RST),
                     32'(drfl_pkg::CLASS_MSK_RST), 32'(drfl_pkg::PAD_RST),
                     32'(drfl_pkg::PAD_RST), 32'(drfl_pkg::INV_SCALE_RST)};
        1: cfg_v = '{32'd0, 32'd0, 32'd63, 32'd0, 32'd0, 32'd1};
        2: cfg_v = '{32'd1022, 32'd1023, 32'd63, 32'd1023, 32'd1023, 32'hFF_FFFF};
        4: cfg_v[drfl_pkg::REG_INV_SCALE] = 32'd0;
        default: ;
      endcase
      for (int i = 0; i <= drfl_pkg::REG_INV_SCALE; i++) set_reg(3'(i), cfg_v[i]);
      set_reg(REG_UNMAPPED, $urandom);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        r = gen_row();
        send_row(r);
        if (decode_row(r, o)) expect_row(o);
        idle_maybe(ph != 3);  // phase 3 runs back to back
      end
    end

    quiesce();
    if (mismatches == 0)
      $display("detection_row_filter_landmark_decode: match");
    else
      $display("detection_row_filter_landmark_decode: mismatch");
    $finish;
  end

endmodule

@@ detection_row_filter_landmark_decode.f @@
+incdir+rtl
rtl/drfl_pkg.sv
rtl/detection_row_filter_landmark_decode.sv
test/detection_row_filter_landmark_decode_tb.sv
